/* rtl/core/dns_pkg.sv */
// Package for the DNS A-record response parser: constants, status codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package dns_pkg;
  localparam int MsgBytesDef  = 512;
  localparam int NameBytesDef = 256;
  localparam int MaxLabelDef  = 63;
  localparam int MaxJumpsDef  = 16;
  localparam int MaxAddrsDef  = 16;

  localparam logic [15:0] FlagQr     = 16'h8000;
  localparam logic [15:0] FlagOpcode = 16'h7800;
  localparam logic [15:0] FlagTc     = 16'h0200;
  localparam logic [15:0] FlagRcode  = 16'h000f;
  localparam logic [7:0]  PtrMask    = 8'hc0;
  localparam logic [7:0]  PtrLow     = 8'h3f;
  localparam int HdrLen   = 12;
  localparam int RrFixed  = 10;
  localparam int QFixed   = 4;
  localparam logic [3:0] RcNxdomain = 4'd3;
  localparam logic [15:0] TypeA   = 16'd1;
  localparam logic [15:0] ClassIn = 16'd1;

  localparam logic [0:0] CfgExpectedId  = 1'b0;
  localparam logic [0:0] CfgMaxAddresses = 1'b1;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StNotFound  = 3'd1,
    StTrunc     = 3'd2,
    StMalformed = 3'd3,
    StTooMany   = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_HDR, S_NAME_B, S_PTR, S_LBL_CMP, S_LBL_CHR, S_NAME_END,
    S_QFIX, S_RR_START, S_RRFIX, S_RR_ADDR, S_DONE, S_EMIT, S_EMIT_ADDR
  } state_e;

  function automatic logic [7:0] lower8(input logic [7:0] c);
    lower8 = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction
endpackage

/* rtl/core/dns_if.sv */
// Valid/ready channel interfaces for input bytes, results and configuration writes.
// No dependencies.
`timescale 1ns / 1ps
interface dns_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic       last;
  modport source (output valid, mode, data_byte, last, input ready);
  modport sink   (input valid, mode, data_byte, last, output ready);
endinterface

interface dns_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] address;
  logic        final_res;
  modport source (output valid, status, address, final_res, input ready);
  modport sink   (input valid, status, address, final_res, output ready);
endinterface

interface dns_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/dns_seq.sv */
// Parse sequencer: walks the message memory one byte per step with one shared adder.
// Depends on dns_pkg.
`timescale 1ns / 1ps
module dns_seq #(
  parameter int MsgBytes  = dns_pkg::MsgBytesDef,
  parameter int NameBytes = dns_pkg::NameBytesDef,
  parameter int MaxLabel  = dns_pkg::MaxLabelDef,
  parameter int MaxJumps  = dns_pkg::MaxJumpsDef,
  parameter int MaxAddrs  = dns_pkg::MaxAddrsDef,
  localparam int MLW = $clog2(MsgBytes + 1),
  localparam int NLW = $clog2(NameBytes + 1),
  localparam int AW  = $clog2(MaxAddrs + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [MLW-1:0] msg_len_i,
  input  logic [NLW-1:0] name_len_i,
  input  logic [15:0] exp_id_i,
  input  logic [4:0]  max_addr_i,
  output logic [MLW-1:0] mrd_addr_o,
  input  logic [7:0]  mrd_data_i,
  output logic [NLW-1:0] nrd_addr_o,
  input  logic [7:0]  nrd_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  out_status_o,
  output logic [31:0] out_address_o,
  output logic        out_final_o
);
  import dns_pkg::*;
  localparam int PW = MLW + 16;
  localparam int JW = $clog2(MaxJumps + 2);
  localparam int AIW = (MaxAddrs > 1) ? $clog2(MaxAddrs) : 1;

  state_e state_q, state_d, ret_q, ret_d;
  logic [PW-1:0] pos_q, pos_d, next_q, next_d, rd_q, rd_d;
  logic [3:0] cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic [NLW:0] q_q, q_d;
  logic [6:0] lbl_q, lbl_d;
  logic [JW-1:0] jumps_q, jumps_d;
  logic jumped_q, jumped_d, match_q, match_d;
  logic [15:0] an_q, an_d, type_q, type_d, klass_q, klass_d;
  logic [2:0] st_q, st_d;
  logic [AW-1:0] acnt_q, acnt_d, ek_q, ek_d;
  logic [7:0] b_q, b_d;
  logic [31:0] addrs_q [MaxAddrs];
  logic wr_en;
  logic [PW-1:0] len_x, sum;
  logic [AW-1:0] cap;
  logic [PW-1:0] add_a, add_b;

  assign len_x = PW'(msg_len_i);
  assign sum = add_a + add_b;
  assign cap = (32'(max_addr_i) < MaxAddrs) ? AW'(max_addr_i) : AW'(MaxAddrs);
  assign mrd_addr_o = (rd_q < PW'(MsgBytes)) ? MLW'(rd_q) : '0;
  assign nrd_addr_o = NLW'(q_q);
  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q <= ret_d; pos_q <= pos_d; next_q <= next_d; rd_q <= rd_d; cnt_q <= cnt_d;
    acc_q <= acc_d; q_q <= q_d; lbl_q <= lbl_d; jumps_q <= jumps_d; jumped_q <= jumped_d;
    match_q <= match_d; an_q <= an_d; type_q <= type_d; klass_q <= klass_d;
    st_q <= st_d; acnt_q <= acnt_d; ek_q <= ek_d; b_q <= b_d;
    if (wr_en) begin
      addrs_q[AIW'(acnt_q)] <= acc_d;
    end
  end

  // Byte fetch: rd_q addresses memory; the registered read data is valid in the state S_RD returns to.
  always_comb begin
    state_d = state_q; ret_d = ret_q; pos_d = pos_q; next_d = next_q; rd_d = rd_q;
    cnt_d = cnt_q; acc_d = acc_q; q_d = q_q; lbl_d = lbl_q; jumps_d = jumps_q;
    jumped_d = jumped_q; match_d = match_q; an_d = an_q; type_d = type_q;
    klass_d = klass_q; st_d = st_q; acnt_d = acnt_q; ek_d = ek_q; b_d = b_q;
    wr_en = 1'b0; add_a = pos_q; add_b = '0;
    out_valid_o = 1'b0; out_status_o = st_q; out_address_o = '0; out_final_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          acnt_d = '0; ek_d = '0;
          if (msg_len_i < MLW'(HdrLen)) begin
            st_d = StMalformed; state_d = S_EMIT;
          end else begin
            rd_d = '0; cnt_d = 4'd0; state_d = S_HDR;
          end
        end
      end
      S_HDR: begin
        // 8 header bytes, one per cycle; fetched byte at rd_q-1 appears now
        if (cnt_q != 4'd0) begin
          acc_d = {acc_q[23:0], (rd_q - PW'(1) < PW'(MsgBytes)) ? mrd_data_i : 8'h00};
        end
        unique case (cnt_q)
          4'd4: begin
            if (acc_d[31:16] != exp_id_i || !acc_d[15] || (acc_d[15:0] & FlagOpcode) != 0) begin
              st_d = StMalformed; state_d = S_EMIT;
            end else if ((acc_d[15:0] & FlagTc) != 0) begin
              st_d = StTrunc; state_d = S_EMIT;
            end else if (acc_d[3:0] == RcNxdomain) begin
              st_d = StNotFound; state_d = S_EMIT;
            end else if (acc_d[3:0] != 4'd0) begin
              st_d = StMalformed; state_d = S_EMIT;
            end
          end
          4'd8: begin
            an_d = acc_d[15:0];
            if (acc_d[31:16] != 16'd1) begin
              st_d = StMalformed; state_d = S_EMIT;
            end else begin
              pos_d = PW'(HdrLen); match_d = 1'b1; q_d = '0; jumps_d = '0;
              jumped_d = 1'b0; rd_d = PW'(HdrLen); state_d = S_RD; ret_d = S_NAME_B;
            end
          end
          default: ;
        endcase
        if (cnt_q != 4'd8 && state_d == S_HDR) begin
          rd_d = rd_q + PW'(1); cnt_d = cnt_q + 4'd1;
        end
      end
      S_RD: begin
        state_d = ret_q;
      end
      S_NAME_B: begin
        b_d = (rd_q < PW'(MsgBytes)) ? mrd_data_i : 8'h00;
        if (pos_q >= len_x) begin
          st_d = StMalformed; state_d = S_EMIT;
        end else if ((b_d & PtrMask) == PtrMask) begin
          add_b = PW'(1);
          if (sum >= len_x || jumps_q == JW'(MaxJumps)) begin
            st_d = StMalformed; state_d = S_EMIT;
          end else begin
            jumps_d = jumps_q + JW'(1); rd_d = sum; state_d = S_RD; ret_d = S_PTR;
          end
        end else begin
          add_b = PW'(b_d) + PW'(1);
          if ((b_d & PtrMask) != 0 || b_d > 8'(MaxLabel) || sum > len_x) begin
            st_d = StMalformed; state_d = S_EMIT;
          end else begin
            lbl_d = 7'(b_d); rd_d = pos_q + PW'(1);
            state_d = match_q ? S_LBL_CMP : S_NAME_END;
          end
        end
      end
      S_PTR: begin
        add_a = PW'({b_q & PtrLow, (rd_q < PW'(MsgBytes)) ? mrd_data_i : 8'h00});
        if (add_a >= len_x) begin
          st_d = StMalformed; state_d = S_EMIT;
        end else begin
          if (!jumped_q) begin
            next_d = pos_q + PW'(2); jumped_d = 1'b1;
          end
          pos_d = add_a; rd_d = add_a; state_d = S_RD; ret_d = S_NAME_B;
        end
      end
      S_LBL_CMP: begin
        // name_store[q] read registered via nrd_addr; compare length byte
        if (q_q >= (NLW+1)'(name_len_i) || nrd_data_i != b_q) begin
          st_d = StMalformed; state_d = S_EMIT;
        end else begin
          q_d = q_q + (NLW+1)'(1);
          state_d = (lbl_q == 7'd0) ? S_NAME_END : S_RD;
          ret_d = S_LBL_CHR;
        end
      end
      S_LBL_CHR: begin
        if (q_q >= (NLW+1)'(name_len_i) ||
            lower8((rd_q < PW'(MsgBytes)) ? mrd_data_i : 8'h00) != lower8(nrd_data_i)) begin
          st_d = StMalformed; state_d = S_EMIT;
        end else begin
          q_d = q_q + (NLW+1)'(1); lbl_d = lbl_q - 7'd1; rd_d = rd_q + PW'(1);
          state_d = (lbl_q == 7'd1) ? S_NAME_END : S_RD;
        end
      end
      S_NAME_END: begin
        add_b = PW'(b_q) + PW'(1);
        pos_d = sum;
        if (b_q != 8'd0) begin
          rd_d = sum; state_d = S_RD; ret_d = S_NAME_B;
        end else if (match_q && q_q != (NLW+1)'(name_len_i)) begin
          st_d = StMalformed; state_d = S_EMIT;
        end else begin
          if (jumped_q) pos_d = next_q;
          state_d = match_q ? S_QFIX : S_RRFIX;
          rd_d = jumped_q ? next_q : sum; cnt_d = '0; acc_d = '0;
        end
      end
      S_QFIX: begin
        add_b = PW'(QFixed);
        if (sum > len_x) begin
          st_d = StMalformed; state_d = S_EMIT;
        end else begin
          if (cnt_q != 4'd0) acc_d = {acc_q[23:0], mrd_data_i};
          if (cnt_q == 4'd4) begin
            if (acc_d != {TypeA, ClassIn}) begin
              st_d = StMalformed; state_d = S_EMIT;
            end else begin
              pos_d = sum; state_d = S_RR_START;
            end
          end else begin
            rd_d = rd_q + PW'(1); cnt_d = cnt_q + 4'd1;
          end
        end
      end
      S_RR_START: begin
        if (an_q == 16'd0) begin
          st_d = (acnt_q == '0) ? StNotFound : StOk; state_d = S_EMIT;
        end else begin
          an_d = an_q - 16'd1; match_d = 1'b0; jumps_d = '0; jumped_d = 1'b0;
          rd_d = pos_q; state_d = S_RD; ret_d = S_NAME_B;
        end
      end
      S_RRFIX: begin
        add_b = PW'(RrFixed);
        if (sum > len_x) begin
          st_d = StMalformed; state_d = S_EMIT;
        end else begin
          if (cnt_q != 4'd0) acc_d = {acc_q[23:0], mrd_data_i};
          if (cnt_q == 4'd4) begin
            type_d = acc_d[31:16]; klass_d = acc_d[15:0];
          end
          if (cnt_q == 4'd10) begin
            pos_d = sum; acc_d = {16'd0, acc_q[7:0], mrd_data_i};
            state_d = S_DONE;
          end else begin
            rd_d = rd_q + PW'(1); cnt_d = cnt_q + 4'd1;
          end
        end
      end
      S_DONE: begin
        add_b = PW'(acc_q[15:0]);
        if (sum > len_x) begin
          st_d = StMalformed; state_d = S_EMIT;
        end else if (type_q == TypeA && klass_q == ClassIn) begin
          if (acc_q[15:0] != 16'd4) begin
            st_d = StMalformed; state_d = S_EMIT;
          end else if (acnt_q >= cap) begin
            st_d = StTooMany; state_d = S_EMIT;
          end else begin
            rd_d = pos_q; cnt_d = '0; acc_d = '0; state_d = S_RR_ADDR;
          end
        end else begin
          pos_d = sum; state_d = S_RR_START;
        end
      end
      S_RR_ADDR: begin
        if (cnt_q != 4'd0) acc_d = {acc_q[23:0], mrd_data_i};
        if (cnt_q == 4'd4) begin
          add_b = PW'(4); pos_d = sum; state_d = S_RR_START;
        end else begin
          rd_d = rd_q + PW'(1); cnt_d = cnt_q + 4'd1;
        end
      end
      S_EMIT: begin
        if (st_q == StOk) begin
          state_d = S_EMIT_ADDR;
        end else begin
          out_valid_o = 1'b1;
          if (out_ready_i) state_d = S_IDLE;
        end
      end
      S_EMIT_ADDR: begin
        out_valid_o = 1'b1; out_status_o = StOk;
        out_address_o = addrs_q[AIW'(ek_q)];
        out_final_o = (ek_q + AW'(1) == acnt_q);
        if (out_ready_i) begin
          ek_d = ek_q + AW'(1);
          if (out_final_o) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // address write commits when the fourth byte lands
    if (state_q == S_RR_ADDR && cnt_q == 4'd4) begin
      wr_en = 1'b1; acnt_d = acnt_q + AW'(1);
    end
  end
endmodule

/* rtl/core/dns_a_record_response_parser_top.sv */
// Top level of the DNS A-record response parser: byte stores, config registers, sequencer.
// Depends on dns_pkg, dns_if, dns_seq.
`timescale 1ns / 1ps
// Name and message bytes load at one word per cycle while no parse runs. The last message
// word starts a parse that holds the input off: it reads the header, then each question
// label and its characters, any compression pointers and the question type and class, and
// per answer starts the record, skips its name labels, reads the fixed fields, checks the
// data length and loads an A address. A check that fails ends the parse at once. Results
// then leave one per cycle while ready is high, after an extra S_EMIT state for addresses.
module dns_a_record_response_parser_top #(
  parameter int MsgBytes  = dns_pkg::MsgBytesDef,
  parameter int NameBytes = dns_pkg::NameBytesDef,
  parameter int MaxLabel  = dns_pkg::MaxLabelDef,
  parameter int MaxJumps  = dns_pkg::MaxJumpsDef,
  parameter int MaxAddrs  = dns_pkg::MaxAddrsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  dns_in_if.sink    in_if,
  dns_out_if.source out_if,
  dns_cfg_if.sink   cfg_if
);
  import dns_pkg::*;
  localparam int MLW = $clog2(MsgBytes + 1);
  localparam int NLW = $clog2(NameBytes + 1);
  localparam int MAW = $clog2(MsgBytes);
  localparam int NAW = (NameBytes > 1) ? $clog2(NameBytes) : 1;

  logic [7:0] msg_mem [MsgBytes];
  logic [7:0] name_mem [NameBytes];
  logic [MLW-1:0] msg_len_q;
  logic [NLW-1:0] name_len_q;
  logic msg_open_q, name_open_q;
  logic [15:0] exp_id_q;
  logic [4:0] max_addr_q;
  logic [7:0] mrd_q, nrd_q;
  logic [MLW-1:0] mrd_addr, mlen_eff;
  logic [NLW-1:0] nrd_addr, nlen_eff;
  logic busy, start, acc;

  assign in_if.ready = !busy;
  assign cfg_if.ready = 1'b1;
  assign acc = in_if.valid && in_if.ready;
  assign start = acc && in_if.mode && in_if.last;
  assign mlen_eff = msg_open_q ? msg_len_q : '0;
  assign nlen_eff = name_open_q ? name_len_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_len_q <= '0; name_len_q <= '0; msg_open_q <= 1'b0; name_open_q <= 1'b0;
      exp_id_q <= '0; max_addr_q <= 5'd16;
    end else begin
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          CfgExpectedId:   exp_id_q <= cfg_if.data;
          CfgMaxAddresses: max_addr_q <= cfg_if.data[4:0];
          default: ;
        endcase
      end
      if (acc && in_if.mode) begin
        msg_open_q <= !in_if.last;
        if (mlen_eff < MLW'(MsgBytes)) msg_len_q <= mlen_eff + MLW'(1);
        else msg_len_q <= mlen_eff;
      end
      if (acc && !in_if.mode) begin
        name_open_q <= !in_if.last;
        if (nlen_eff < NLW'(NameBytes)) name_len_q <= nlen_eff + NLW'(1);
        else name_len_q <= nlen_eff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && in_if.mode && mlen_eff < MLW'(MsgBytes))
      msg_mem[MAW'(mlen_eff)] <= in_if.data_byte;
    if (acc && !in_if.mode && nlen_eff < NLW'(NameBytes))
      name_mem[NAW'(nlen_eff)] <= in_if.data_byte;
    mrd_q <= msg_mem[MAW'(mrd_addr)];
    nrd_q <= name_mem[NAW'(nrd_addr)];
  end

  dns_seq #(
    .MsgBytes(MsgBytes), .NameBytes(NameBytes), .MaxLabel(MaxLabel),
    .MaxJumps(MaxJumps), .MaxAddrs(MaxAddrs)
  ) u_seq (
    .clk_i, .rst_ni,
    .start_i(start), .busy_o(busy),
    .msg_len_i(busy ? msg_len_q :
               (mlen_eff < MLW'(MsgBytes) ? mlen_eff + MLW'(1) : mlen_eff)),
    .name_len_i(name_len_q), .exp_id_i(exp_id_q), .max_addr_i(max_addr_q),
    .mrd_addr_o(mrd_addr), .mrd_data_i(mrd_q),
    .nrd_addr_o(nrd_addr), .nrd_data_i(nrd_q),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .out_status_o(out_if.status), .out_address_o(out_if.address),
    .out_final_o(out_if.final_res)
  );

  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("input ready while results pending");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !in_if.ready) else $error("parser not busy after last byte");
  a_err_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.status != StOk) |-> (out_if.address == 32'd0 && out_if.final_res))
    else $error("error result malformed");
endmodule

/* sim/tb.sv */
// Testbench for dns_a_record_response_parser_top: name and response words with checked results.
// Depends on dns_pkg, dns_if and the top level; predicts every result internally.
`timescale 1ns / 1ps
module tb;
  import dns_pkg::*;

  typedef logic [7:0] byte_q_t[$];
  typedef struct {
    bit         mode;
    logic [7:0] data;
    bit         last;
  } word_t;
  typedef struct {
    status_e     status;
    logic [31:0] address;
    bit          final_res;
  } answer_t;

  localparam int unsigned CycleLimit = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  dns_in_if  in_if();
  dns_out_if out_if();
  dns_cfg_if cfg_if();

  dns_a_record_response_parser_top u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  word_t       word_q[$];
  answer_t     answer_q[$];
  logic [31:0] found_q[$];
  logic [7:0]  msg_mem[MsgBytesDef];
  logic [7:0]  name_mem[NameBytesDef];
  int unsigned msg_len, name_len;
  bit          msg_open, name_open;
  logic [15:0] cur_id;
  logic [4:0]  cur_max;
  bit          in_fire, calm;
  int unsigned errors, cycles;
  byte_q_t     cur_name;

  function automatic int unsigned rd8(int unsigned p);
    return (p < MsgBytesDef) ? int'(msg_mem[p]) : 0;
  endfunction

  function automatic int unsigned rd16(int unsigned p);
    return (rd8(p) << 8) | rd8(p + 1);
  endfunction

  function automatic logic [7:0] fold(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction

  function automatic bit walk_name(int unsigned len, inout int unsigned off, input bit match);
    int unsigned pos, q, jumps, nxt, b, ptr;
    bit jumped;
    pos = off; q = 0; jumps = 0; nxt = 0; jumped = 0;
    forever begin
      if (pos >= len) return 0;
      b = rd8(pos);
      if ((b & PtrMask) == PtrMask) begin
        if (pos + 1 >= len) return 0;
        jumps++;
        if (jumps > MaxJumpsDef) return 0;
        ptr = ((b & PtrLow) << 8) | rd8(pos + 1);
        if (ptr >= len) return 0;
        if (!jumped) begin
          nxt = pos + 2;
          jumped = 1;
        end
        pos = ptr;
        continue;
      end
      if ((b & PtrMask) != 0 || b > MaxLabelDef || pos + 1 + b > len) return 0;
      if (match) begin
        if (q >= name_len || name_mem[q] != b) return 0;
        q++;
        for (int i = 0; i < b; i++) begin
          if (q + i >= name_len || fold(8'(rd8(pos + 1 + i))) != fold(name_mem[q + i]))
            return 0;
        end
        q += b;
      end
      pos += 1 + b;
      if (b == 0) break;
    end
    if (match && q != name_len) return 0;
    off = jumped ? nxt : pos;
    return 1;
  endfunction

  function automatic status_e parse_response();
    int unsigned len, flags, ancount, pos, cap, rtype, rclass, rdlen;
    len = msg_len;
    found_q.delete();
    cap = (cur_max < MaxAddrsDef) ? cur_max : MaxAddrsDef;
    if (len < HdrLen || rd16(0) != cur_id) return StMalformed;
    flags = rd16(2);
    if ((flags & FlagQr) == 0 || (flags & FlagOpcode) != 0) return StMalformed;
    if ((flags & FlagTc) != 0) return StTrunc;
    if ((flags & FlagRcode) == RcNxdomain) return StNotFound;
    if ((flags & FlagRcode) != 0 || rd16(4) != 1) return StMalformed;
    ancount = rd16(6);
    pos = HdrLen;
    if (!walk_name(len, pos, 1)) return StMalformed;
    if (pos + QFixed > len || rd16(pos) != TypeA || rd16(pos + 2) != ClassIn) return StMalformed;
    pos += QFixed;
    for (int unsigned i = 0; i < ancount; i++) begin
      if (!walk_name(len, pos, 0)) return StMalformed;
      if (pos + RrFixed > len) return StMalformed;
      rtype = rd16(pos);
      rclass = rd16(pos + 2);
      rdlen = rd16(pos + 8);
      pos += RrFixed;
      if (pos + rdlen > len) return StMalformed;
      if (rtype == TypeA && rclass == ClassIn) begin
        if (rdlen != 4) return StMalformed;
        if (found_q.size() >= cap) return StTooMany;
        found_q.push_back(32'((rd16(pos) << 16) | rd16(pos + 2)));
      end
      pos += rdlen;
    end
    return (found_q.size() == 0) ? StNotFound : StOk;
  endfunction

  task automatic predict_word(word_t w);
    status_e st;
    if (!w.mode) begin
      if (!name_open) begin
        name_len = 0;
        name_open = 1;
      end
      if (name_len < NameBytesDef) name_mem[name_len++] = w.data;
      if (w.last) name_open = 0;
    end else begin
      if (!msg_open) begin
        msg_len = 0;
        msg_open = 1;
      end
      if (msg_len < MsgBytesDef) msg_mem[msg_len++] = w.data;
      if (w.last) begin
        msg_open = 0;
        st = parse_response();
        if (st != StOk) answer_q.push_back('{st, 32'd0, 1'b1});
        else
          foreach (found_q[k]) answer_q.push_back('{StOk, found_q[k], k == found_q.size() - 1});
      end
    end
  endtask

  task automatic fail(string what);
    errors++;
    if (errors <= 10) $display("mismatch: %s", what);
  endtask

  // result checking and cycle limit
  always @(posedge clk_i) begin : mon
    answer_t a;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
    in_fire = rst_ni && in_if.valid && in_if.ready;
    if (in_fire) predict_word('{in_if.mode, in_if.data_byte, in_if.last});
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (answer_q.size() == 0) begin
        fail($sformatf("unexpected result st=%0d addr=%h fin=%0b",
                       out_if.status, out_if.address, out_if.final_res));
      end else begin
        a = answer_q.pop_front();
        if (out_if.status !== a.status || out_if.address !== a.address ||
            out_if.final_res !== a.final_res)
          fail($sformatf("exp st=%0d addr=%h fin=%0b got st=%0d addr=%h fin=%0b",
                         a.status, a.address, a.final_res,
                         out_if.status, out_if.address, out_if.final_res));
      end
    end
  end

  // word driver and result back-pressure
  always @(negedge clk_i) begin : drv
    word_t w;
    if (rst_ni) begin
      if (!in_if.valid || in_fire) begin
        if (word_q.size() > 0 && (calm || $urandom_range(0, 99) >= 31)) begin
          w = word_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.mode      <= w.mode;
          in_if.data_byte <= w.data;
          in_if.last      <= w.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= calm || $urandom_range(0, 99) >= 31;
    end
  end

  task automatic send(bit mode, byte_q_t b);
    foreach (b[i]) word_q.push_back('{mode, b[i], i == b.size() - 1});
  endtask

  task automatic put16(inout byte_q_t m, input int unsigned v);
    m.push_back(v[15:8]);
    m.push_back(v[7:0]);
  endtask

  task automatic header(output byte_q_t m, input int unsigned id, flags, qd, an);
    m = {};
    put16(m, id); put16(m, flags); put16(m, qd); put16(m, an); put16(m, 0); put16(m, 0);
  endtask

  task automatic new_name();
    int unsigned n;
    cur_name = {};
    repeat ($urandom_range(1, 3)) begin
      n = $urandom_range(1, 8);
      cur_name.push_back(n[7:0]);
      repeat (n) cur_name.push_back(8'(8'h61 + $urandom_range(0, 25)));
    end
    cur_name.push_back(8'h00);
  endtask

  function automatic byte_q_t mixed_case(byte_q_t b);
    foreach (b[i]) if (b[i] >= 8'h61 && $urandom_range(0, 1)) b[i] -= 8'h20;
    return b;
  endfunction

  // response with n_a A records then n_other CNAME-like records
  task automatic response(output byte_q_t m, input int unsigned id, flags, qd,
                          int unsigned n_a, n_other, a_rdlen, bit full_names);
    byte_q_t q;
    q = mixed_case(cur_name);
    header(m, id, flags, qd, n_a + n_other);
    m = {m, q};
    put16(m, TypeA); put16(m, ClassIn);
    for (int unsigned i = 0; i < n_a + n_other; i++) begin
      if (full_names) m = {m, mixed_case(cur_name)};
      else put16(m, 16'hc00c);
      put16(m, (i < n_a) ? TypeA : 16'd5);
      put16(m, ClassIn);
      put16(m, $urandom); put16(m, $urandom);
      put16(m, (i < n_a) ? a_rdlen : 2);
      repeat ((i < n_a) ? a_rdlen : 2) m.push_back(8'($urandom));
    end
  endtask

  task automatic settle();
    wait (word_q.size() == 0 && !in_if.valid && answer_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [0:0] idx, logic [15:0] v);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = v;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CfgExpectedId) cur_id = v;
    else cur_max = v[4:0];
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic random_message();
    byte_q_t m;
    int unsigned kind, k;
    if ($urandom_range(0, 99) < 20) begin
      new_name();
      send(1'b0, cur_name);
    end
    kind = $urandom_range(0, 99);
    k = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(0, 17);
    response(m, ($urandom_range(0, 99) < 95) ? cur_id : $urandom, FlagQr, 1, k,
             $urandom_range(0, 2), 4, $urandom_range(0, 3) == 0);
    if (kind >= 70 && kind < 85) m[$urandom_range(0, m.size() - 1)] = 8'($urandom);
    else if (kind >= 85 && kind < 92) m = m[0:$urandom_range(0, m.size() - 1)];
    else if (kind >= 92) begin
      m = {};
      repeat ($urandom_range(1, 40)) m.push_back(8'($urandom));
      if ($urandom_range(0, 1)) begin
        m[0] = cur_id[15:8];
        m[1] = cur_id[7:0];
      end
    end
    send(1'b1, m);
  endtask

  initial begin
    byte_q_t m, pad;
    in_if.valid = 1'b0; in_if.mode = 1'b0; in_if.data_byte = 8'h00; in_if.last = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.index = CfgExpectedId; cfg_if.data = 16'h0000;
    cur_id = 16'h0000; cur_max = 5'd16;
    msg_len = 0; name_len = 0; msg_open = 0; name_open = 0;
    errors = 0; cycles = 0; in_fire = 0; calm = 0;
    foreach (msg_mem[i]) msg_mem[i] = 8'h00;
    foreach (name_mem[i]) name_mem[i] = 8'h00;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    cfg_write(CfgExpectedId, 16'hffff);
    cfg_write(CfgMaxAddresses, 16'd16);
    // message before any name: always a mismatch
    response(m, cur_id, FlagQr, 1, 1, 0, 4, 0);
    send(1'b1, m);
    new_name();
    send(1'b0, cur_name);
    response(m, cur_id, FlagQr, 1, 1, 0, 4, 0);       send(1'b1, m);
    response(m, cur_id, FlagQr, 1, 3, 2, 4, 1);       send(1'b1, m);
    response(m, cur_id, FlagQr | 16'd3, 1, 1, 0, 4, 0); send(1'b1, m);
    response(m, cur_id, FlagQr | FlagTc, 1, 1, 0, 4, 0); send(1'b1, m);
    response(m, cur_id, FlagQr | 16'd2, 1, 1, 0, 4, 0); send(1'b1, m);
    response(m, cur_id, 16'h0000, 1, 1, 0, 4, 0);     send(1'b1, m);
    response(m, cur_id, FlagQr | FlagOpcode, 1, 1, 0, 4, 0); send(1'b1, m);
    response(m, 16'h1234, FlagQr, 1, 1, 0, 4, 0);     send(1'b1, m);
    response(m, cur_id, FlagQr, 2, 1, 0, 4, 0);       send(1'b1, m);
    response(m, cur_id, FlagQr, 1, 0, 2, 4, 0);       send(1'b1, m);
    response(m, cur_id, FlagQr, 1, 0, 0, 4, 0);       send(1'b1, m);
    response(m, cur_id, FlagQr, 1, 1, 0, 5, 0);       send(1'b1, m);
    m = {8'hff, 8'hff, 8'h80, 8'h00, 8'h00};          send(1'b1, m);
    // self-referencing pointer, label forms 0x40 and 0x80, pointer out of range or cut
    header(m, cur_id, FlagQr, 1, 0); m = {m, 8'hc0, 8'h0c, 8'h00, 8'h01, 8'h00, 8'h01};
    send(1'b1, m);
    header(m, cur_id, FlagQr, 1, 0); m = {m, 8'h40, 8'h61, 8'h00}; send(1'b1, m);
    header(m, cur_id, FlagQr, 1, 0); m = {m, 8'h80, 8'h61, 8'h00}; send(1'b1, m);
    header(m, cur_id, FlagQr, 1, 0); m = {m, 8'hc1, 8'hff, 8'h00}; send(1'b1, m);
    header(m, cur_id, FlagQr, 1, 0); m = {m, 8'hc0};  send(1'b1, m);
    // message past the store: tail dropped, parse still runs
    response(m, cur_id, FlagQr, 1, 2, 0, 4, 0);
    pad = {};
    repeat (560) pad.push_back(8'($urandom));
    send(1'b1, {m, pad});
    response(m, cur_id, FlagQr, 1, 16, 0, 4, 0);      send(1'b1, m);
    response(m, cur_id, FlagQr, 1, 17, 0, 4, 0);      send(1'b1, m);
    // name past its store, then the real one again
    send(1'b0, pad[0:299]);
    response(m, cur_id, FlagQr, 1, 1, 0, 4, 0);       send(1'b1, m);
    send(1'b0, cur_name);
    settle();

    cfg_write(CfgExpectedId, 16'h0000);
    cfg_write(CfgMaxAddresses, 16'd1);
    response(m, cur_id, FlagQr, 1, 1, 0, 4, 0);       send(1'b1, m);
    response(m, cur_id, FlagQr, 1, 2, 0, 4, 0);       send(1'b1, m);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(CfgExpectedId, 16'($urandom));
      case (ph)
        0: cfg_write(CfgMaxAddresses, 16'd0);
        1: cfg_write(CfgMaxAddresses, 16'd31);
        default: cfg_write(CfgMaxAddresses, 16'($urandom_range(1, 16)));
      endcase
      calm = (ph == 3);
      repeat (9) random_message();
      settle();
    end
    calm = 0;
    settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/dns_pkg.sv
rtl/core/dns_if.sv
rtl/core/dns_seq.sv
rtl/core/dns_a_record_response_parser_top.sv
sim/tb.sv
